### src/assert_macros.svh
// Assertion macros used by the checker file of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, held off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ld12_pkg.sv
// Shared types and constants of the 12-bit dictionary decoder.
// No dependencies; imported by the top level, the unpacker and the checker.
package ld12_pkg;

    // Default code width and the fixed widths of the packed stream.
    localparam int CODE_WIDTH_DEF = 12;
    localparam int PACKED_W       = 12;
    localparam int BYTE_W         = 8;
    localparam int NIBBLE_W       = 4;
    localparam int LIT_BITS       = 8;
    localparam int LITERAL_LIMIT  = 256;

    // Input beat modes.
    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // Result beat kinds.
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_REFUSED = 1'b1;

    // Unpacking phases: bytes seen of the current three-byte group.
    localparam logic [1:0] PHASE_EMPTY = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_REFUSE,
        ST_LOOKUP,
        ST_FETCH
    } dec_state_t;

    // A code finished by the unpacker on the current byte.
    typedef struct packed {
        logic                done;
        logic [PACKED_W-1:0] code;
    } code_beat_t;

endpackage

### src/lzw_decoder_12bit_top.sv
// Top level of the 12-bit dictionary decoder: sequencer, link and stack RAMs.
// A drain of a non-empty stack or a refused data beat moves the sequencer to ST_DRAIN or
// ST_REFUSE, which loads the result register once it is free; in_ready is low until idle.
// A decoded code holds in_ready low while its string is walked onto the stack, one link
// a cycle through the link RAM read port. Reset clears all control state; RAM contents
// are undefined until written. Depends on ld12_pkg, ld12_ram and ld12_unpack.
module lzw_decoder_12bit_top #(
    parameter int CODE_WIDTH = ld12_pkg::CODE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_string,
    output logic       kind
);
    import ld12_pkg::*;

    localparam int COUNT_W = CODE_WIDTH + 1;
    localparam int LINK_W  = CODE_WIDTH + BYTE_W;

    dec_state_t state_reg, state_next;

    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COUNT_W-1:0]    nfc_reg, nfc_next;
    logic [CODE_WIDTH-1:0] prev_code_reg, prev_code_next;
    logic                  prev_present_reg, prev_present_next;
    logic [BYTE_W-1:0]     prev_head_reg, prev_head_next;
    logic [CODE_WIDTH-1:0] c_reg, c_next;
    logic [BYTE_W-1:0]     last_reg, last_next;
    logic [CODE_WIDTH-1:0] code_reg, code_next;
    logic                  undef_reg, undef_next;
    logic                  drain_last_reg, drain_last_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_kind_reg, out_kind_next;

    // Unpacker interface.
    logic       advance;
    code_beat_t beat;
    logic [PACKED_W+CODE_WIDTH-1:0] code_wide;
    logic [CODE_WIDTH-1:0]          new_code;
    logic                           new_undef;

    // RAM ports.
    logic                  link_we, link_re;
    logic [CODE_WIDTH-1:0] link_waddr, link_raddr;
    logic [LINK_W-1:0]     link_wdata, link_rdata;
    logic                  stk_we, stk_re;
    logic [CODE_WIDTH-1:0] stk_waddr, stk_raddr;
    logic [BYTE_W-1:0]     stk_wdata, stk_rdata;

    // Helpers.
    logic                  accept;
    logic                  slot_free;
    logic [COUNT_W-1:0]    count_inc, count_dec, nfc_eff;
    logic [CODE_WIDTH-1:0] fetch_prefix;
    logic [BYTE_W-1:0]     fetch_tail;
    logic [BYTE_W-1:0]     head_byte;
    logic                  finish;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign advance   = accept && (mode == MODE_DATA) && (count_reg == '0);

    // Packed code brought to the dictionary width.
    assign code_wide = {{CODE_WIDTH{1'b0}}, beat.code};
    assign new_code  = code_wide[CODE_WIDTH-1:0];
    assign new_undef = ({1'b0, new_code} >= nfc_reg);

    // Link word: prefix code above the tail byte.
    assign fetch_prefix = link_rdata[LINK_W-1:BYTE_W];
    assign fetch_tail   = link_rdata[BYTE_W-1:0];

    // Insert slot, wrapping to the first string code when the table is full.
    assign nfc_eff = nfc_reg[CODE_WIDTH] ? COUNT_W'(LITERAL_LIMIT) : nfc_reg;

    ld12_unpack u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (data_byte),
        .beat      (beat)
    );

    ld12_ram #(
        .DATA_W (LINK_W),
        .ADDR_W (CODE_WIDTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    ld12_ram #(
        .DATA_W (BYTE_W),
        .ADDR_W (CODE_WIDTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Sequencer: next state, RAM controls and register updates.
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        nfc_next          = nfc_reg;
        prev_code_next    = prev_code_reg;
        prev_present_next = prev_present_reg;
        prev_head_next    = prev_head_reg;
        c_next            = c_reg;
        last_next         = last_reg;
        code_next         = code_reg;
        undef_next        = undef_reg;
        drain_last_next   = drain_last_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_byte_next     = out_byte_reg;
        out_last_next     = out_last_reg;
        out_kind_next     = out_kind_reg;
        link_we           = 1'b0;
        link_waddr        = nfc_eff[CODE_WIDTH-1:0];
        link_wdata        = {prev_code_reg, last_reg};
        link_re           = 1'b0;
        link_raddr        = c_reg;
        stk_we            = 1'b0;
        stk_waddr         = count_reg[CODE_WIDTH-1:0];
        stk_wdata         = prev_head_reg;
        stk_re            = 1'b0;
        stk_raddr         = count_dec[CODE_WIDTH-1:0];
        head_byte         = last_reg;
        finish            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_DRAIN)
                    begin
                        // Pop the top of the stack; nothing to do when empty.
                        if (count_reg != '0)
                        begin
                            stk_re          = 1'b1;
                            count_next      = count_dec;
                            drain_last_next = (count_reg == COUNT_W'(1));
                            state_next      = ST_DRAIN;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = ST_REFUSE;
                    end
                    else if (beat.done && !(new_undef && !prev_present_reg))
                    begin
                        code_next  = new_code;
                        undef_next = new_undef;
                        last_next  = '0;
                        if (new_undef)
                        begin
                            // Unknown code: previous string plus its own head.
                            stk_we     = 1'b1;
                            count_next = count_inc;
                            c_next     = prev_code_reg;
                        end
                        else
                        begin
                            c_next = new_code;
                        end
                        state_next = ST_LOOKUP;
                    end
                end
            end

            ST_DRAIN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = stk_rdata;
                    out_last_next  = drain_last_reg;
                    out_kind_next  = KIND_BYTE;
                    state_next     = ST_IDLE;
                end
            end

            ST_REFUSE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_last_next  = 1'b0;
                    out_kind_next  = KIND_REFUSED;
                    state_next     = ST_IDLE;
                end
            end

            ST_LOOKUP:
            begin
                if (count_reg[CODE_WIDTH])
                begin
                    // Stack full: the last byte stacked stands as the head.
                    finish = 1'b1;
                end
                else if (c_reg[CODE_WIDTH-1:LIT_BITS] == '0)
                begin
                    stk_we     = 1'b1;
                    stk_wdata  = c_reg[BYTE_W-1:0];
                    count_next = count_inc;
                    head_byte  = c_reg[BYTE_W-1:0];
                    finish     = 1'b1;
                end
                else
                begin
                    link_re    = 1'b1;
                    state_next = ST_FETCH;
                end
            end

            ST_FETCH:
            begin
                // Stack the tail byte and follow the prefix straight away.
                stk_we     = 1'b1;
                stk_wdata  = fetch_tail;
                count_next = count_inc;
                last_next  = fetch_tail;
                link_raddr = fetch_prefix;
                if ((fetch_prefix[CODE_WIDTH-1:LIT_BITS] != '0) && !count_inc[CODE_WIDTH])
                begin
                    link_re = 1'b1;
                end
                else
                begin
                    c_next     = fetch_prefix;
                    state_next = ST_LOOKUP;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // End of a walk: add the dictionary entry and move the history on.
        if (finish)
        begin
            link_wdata = {prev_code_reg, head_byte};
            if (prev_present_reg)
            begin
                link_we  = 1'b1;
                nfc_next = nfc_eff + 1'b1;
            end
            prev_code_next    = undef_reg ? nfc_eff[CODE_WIDTH-1:0] : code_reg;
            prev_head_next    = head_byte;
            prev_present_next = 1'b1;
            state_next        = ST_IDLE;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            nfc_reg          <= COUNT_W'(LITERAL_LIMIT);
            prev_code_reg    <= '0;
            prev_present_reg <= 1'b0;
            prev_head_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            nfc_reg          <= nfc_next;
            prev_code_reg    <= prev_code_next;
            prev_present_reg <= prev_present_next;
            prev_head_reg    <= prev_head_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        c_reg          <= c_next;
        last_reg       <= last_next;
        code_reg       <= code_next;
        undef_reg      <= undef_next;
        drain_last_reg <= drain_last_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_kind_reg   <= out_kind_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign last_of_string = out_last_reg;
    assign kind           = out_kind_reg;

endmodule

### src/ld12_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing; used for the dictionary links and the output stack.
module ld12_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/ld12_unpack.sv
// Unpacker: gathers bytes into 12-bit codes, two codes per three bytes.
// Depends on ld12_pkg.
module ld12_unpack (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [7:0]             data_byte,
    output ld12_pkg::code_beat_t   beat
);
    import ld12_pkg::*;

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [BYTE_W-1:0] held_reg;
    logic [BYTE_W-1:0] held_next;

    // Code completion and next phase for the byte on offer.
    always_comb
    begin
        beat       = '0;
        phase_next = phase_reg;
        held_next  = held_reg;
        unique case (phase_reg)
            PHASE_ONE:
            begin
                beat.done  = 1'b1;
                beat.code  = {held_reg, data_byte[BYTE_W-1:NIBBLE_W]};
                held_next  = data_byte;
                phase_next = PHASE_TWO;
            end
            PHASE_TWO:
            begin
                beat.done  = 1'b1;
                beat.code  = {held_reg[NIBBLE_W-1:0], data_byte};
                phase_next = PHASE_EMPTY;
            end
            default:
            begin
                // An empty group, and the unused fourth phase, keep the byte.
                held_next  = data_byte;
                phase_next = PHASE_ONE;
            end
        endcase
    end

    // Phase and held byte advance only on a byte that is decoded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_EMPTY;
            held_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

### src/ld12_checker.sv
// Port-level checker for the 12-bit dictionary decoder, bound to the top level.
// Depends on ld12_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ld12_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_string,
    input logic       kind
);
    import ld12_pkg::*;

    // A stalled result beat keeps its payload.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(kind) && $stable(last_of_string), "result beat changed while stalled")

    // A refusal carries a zero byte and no end-of-string mark.
    `ASSERT_IMPL(a_refuse_clean, clk, rst_n, out_valid && (kind == KIND_REFUSED), (out_byte == 8'd0) && !last_of_string, "refusal beat carries data")

    // A result beat only appears after the sequencer has left idle.
    `ASSERT_IMPL(a_rise_after_busy, clk, rst_n, $rose(out_valid), $past(!in_ready), "result beat without a busy cycle")

endmodule

bind lzw_decoder_12bit_top ld12_checker u_checker (.*);

### bench/tb.sv
// Self-checking bench for the 12-bit dictionary decoder: packed code bytes and
// drain beats go in, each result beat is checked against a predictor kept here.
// Depends on ld12_pkg and lzw_decoder_12bit_top.
module tb;
    import ld12_pkg::*;

    localparam int DICT_DEPTH   = 1 << CODE_WIDTH_DEF;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 50;
    localparam int RANDOM_BEATS = 1300;
    localparam int GROWTH_BEATS = 450;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       kind;
    } beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       mode = MODE_DATA;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       last_of_string;
    logic       kind;

    // Decoder state as predicted from the accepted input beats.
    logic [11:0] dict_prefix [DICT_DEPTH];
    logic [7:0]  dict_tail [DICT_DEPTH];
    logic [7:0]  pend_bytes [DICT_DEPTH];
    int unsigned pend_count = 0;
    logic [12:0] next_code = 13'(LITERAL_LIMIT);
    logic [11:0] last_code = '0;
    bit          have_last = 1'b0;
    logic [7:0]  last_head = '0;
    logic [1:0]  pack_phase = PHASE_EMPTY;
    logic [7:0]  pack_held = '0;

    // Result beats still owed by the block, oldest first.
    beat_t owed_beats [$];

    bit steady = 1'b0;
    int unsigned beats_sent = 0;
    int unsigned beats_checked = 0;
    int unsigned codes_decoded = 0;
    int unsigned refusals = 0;
    int unsigned wraps = 0;
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;

    lzw_decoder_12bit_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .last_of_string (last_of_string),
        .kind           (kind)
    );

    always #4 clk = ~clk;

    // Receiver stalls in about a quarter of the cycles, except in the steady stretch.
    always @(posedge clk)
    begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end

    function automatic void push_pending(logic [7:0] b);
        if (pend_count < DICT_DEPTH)
        begin
            pend_bytes[pend_count] = b;
            pend_count++;
        end
    endfunction

    // Stack the string of a code, tail first, and return its first byte.
    // A looping chain stops once the stack is full.
    function automatic logic [7:0] stack_string(logic [11:0] start);
        logic [11:0] c;
        logic [7:0]  tail;
        c = start;
        tail = 8'h00;
        while (c >= LITERAL_LIMIT)
        begin
            if (pend_count >= DICT_DEPTH)
                return tail;
            tail = dict_tail[c];
            push_pending(tail);
            c = dict_prefix[c];
        end
        if (pend_count >= DICT_DEPTH)
            return tail;
        push_pending(c[7:0]);
        return c[7:0];
    endfunction

    // Decode one finished code and add the dictionary entry that follows it.
    function automatic void decode_code(logic [11:0] code);
        bit          undef;
        logic [7:0]  head;
        logic [11:0] slot;
        undef = (code >= next_code);
        slot = '0;
        // An unknown code with no previous string is dropped outright.
        if (undef && !have_last)
            return;
        if (undef)
        begin
            push_pending(last_head);
            head = stack_string(last_code);
        end
        else
        begin
            head = stack_string(code);
        end
        if (have_last)
        begin
            if (next_code >= DICT_DEPTH)
            begin
                next_code = 13'(LITERAL_LIMIT);
                wraps++;
            end
            slot = next_code[11:0];
            dict_prefix[slot] = last_code;
            dict_tail[slot] = head;
            next_code++;
        end
        last_code = undef ? slot : code;
        last_head = head;
        have_last = 1'b1;
        codes_decoded++;
    endfunction

    // Work out the result, if any, of one accepted input beat.
    function automatic void apply_beat(logic m, logic [7:0] b);
        beat_t r;
        if (m == MODE_DRAIN)
        begin
            if (pend_count == 0)
                return;
            pend_count--;
            r.data = pend_bytes[pend_count];
            r.fin = (pend_count == 0);
            r.kind = KIND_BYTE;
            owed_beats = {owed_beats, r};
            return;
        end
        if (pend_count != 0)
        begin
            r = '{8'h00, 1'b0, KIND_REFUSED};
            owed_beats = {owed_beats, r};
            refusals++;
            return;
        end
        case (pack_phase)
            PHASE_ONE:
            begin
                decode_code({pack_held, b[7:4]});
                pack_held = b;
                pack_phase = PHASE_TWO;
            end
            PHASE_TWO:
            begin
                pack_phase = PHASE_EMPTY;
                decode_code({pack_held[3:0], b});
            end
            default:
            begin
                pack_held = b;
                pack_phase = PHASE_ONE;
            end
        endcase
    endfunction

    // Choose a code: known ones near the newest entry, other known codes, some literals,
    // some next-free codes and a few anywhere in the code space; lit_bias favours literals.
    function automatic logic [11:0] pick_code(logic [12:0] nf, bit present, bit lit_bias);
        int unsigned r;
        int unsigned span;
        r = $urandom_range(0, 99);
        if (lit_bias && r < 90)
            r = 0;
        if (r < 12)
            return 12'($urandom_range(0, 255));
        if (r < 24 && present)
            return nf[11:0];
        if (r < 30 || nf <= LITERAL_LIMIT)
            return 12'($urandom_range(0, (nf <= LITERAL_LIMIT) ? 255 : 4095));
        if (r < 75)
        begin
            span = nf - LITERAL_LIMIT;
            if (span > 16)
                span = 16;
            return 12'(nf - 1 - $urandom_range(0, span - 1));
        end
        return 12'($urandom_range(0, nf - 1));
    endfunction

    // Offer one input beat, with a random gap first, and wait for acceptance.
    task automatic send_beat(input logic m, input logic [7:0] b);
        int unsigned gap;
        gap = (!steady && $urandom_range(0, 99) < 25) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        data_byte <= b;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        beats_sent++;
        apply_beat(m, b);
    endtask

    // Drain every pending byte; with noise on, some data beats get refused.
    task automatic drain_pending(input bit noisy);
        while (pend_count != 0)
        begin
            if (noisy && $urandom_range(0, 99) < 4)
                send_beat(MODE_DATA, 8'($urandom));
            send_beat(MODE_DRAIN, 8'($urandom));
        end
    endtask

    // Send two codes as one three-byte group, draining after each decode.
    task automatic send_pair(input bit lit_bias);
        logic [11:0] c1;
        logic [11:0] c2;
        logic [12:0] nf1;
        c1 = pick_code(next_code, have_last, lit_bias);
        nf1 = next_code;
        if (have_last)
            nf1 = (next_code >= DICT_DEPTH) ? 13'(LITERAL_LIMIT + 1) : 13'(next_code + 1);
        c2 = pick_code(nf1, have_last || (c1 < next_code), lit_bias);
        send_beat(MODE_DATA, c1[11:4]);
        send_beat(MODE_DATA, {c1[3:0], c2[11:8]});
        drain_pending(1'b1);
        send_beat(MODE_DATA, c2[7:0]);
        drain_pending(1'b1);
    endtask

    // Hold the sender off until every owed result beat has arrived.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_beats.size() != 0);
    endtask

    // Fresh dictionary: an unknown first code, literals at both ends, an idle
    // drain, a refused byte, the next-free-code case and a two-link string.
    task automatic test_directed();
        send_beat(MODE_DRAIN, 8'hA5);
        send_beat(MODE_DATA, 8'hFF);
        send_beat(MODE_DATA, 8'hF0);
        send_beat(MODE_DRAIN, 8'h5A);
        send_beat(MODE_DATA, 8'h41);
        send_beat(MODE_DATA, 8'h00);
        drain_pending(1'b0);
        send_beat(MODE_DATA, 8'h10);
        send_beat(MODE_DATA, 8'h00);
        drain_pending(1'b0);
        send_beat(MODE_DATA, 8'hFF);
        drain_pending(1'b0);
        send_beat(MODE_DATA, 8'h10);
        send_beat(MODE_DATA, 8'h10);
        drain_pending(1'b0);
        send_beat(MODE_DATA, 8'h00);
        drain_pending(1'b0);
    endtask

    // Mostly well-formed code groups; the rest are stray drains and loose bytes
    // that shift the unpacking phase. A steady stretch and one pause sit inside.
    task automatic test_random_stream();
        int unsigned start;
        int unsigned done_beats;
        bit paused;
        start = beats_sent;
        paused = 1'b0;
        while (beats_sent - start < RANDOM_BEATS)
        begin
            done_beats = beats_sent - start;
            steady = (done_beats >= 500 && done_beats < 750);
            if (!paused && done_beats >= 850)
            begin
                settle();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 15)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_beat(MODE_DRAIN, 8'($urandom));
                else
                    send_beat(MODE_DATA, 8'($urandom));
                drain_pending(1'b1);
            end
            else
            begin
                while (pack_phase != PHASE_EMPTY)
                begin
                    send_beat(MODE_DATA, 8'($urandom));
                    drain_pending(1'b1);
                end
                send_pair(1'b0);
            end
        end
        steady = 1'b0;
    endtask

    // Grow the dictionary with short strings first, then build longer strings
    // on top of the newest entries.
    task automatic test_dictionary_growth();
        int unsigned start;
        start = beats_sent;
        while (pack_phase != PHASE_EMPTY)
        begin
            send_beat(MODE_DATA, 8'($urandom));
            drain_pending(1'b1);
        end
        while (beats_sent - start < GROWTH_BEATS / 2)
            send_pair(1'b1);
        while (beats_sent - start < GROWTH_BEATS)
            send_pair(1'b0);
    endtask

    // Compare each result beat with the oldest one owed.
    always @(posedge clk)
    begin : check_results
        beat_t seen;
        beat_t owed;
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{out_byte, last_of_string, kind};
            beats_checked++;
            if (owed_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: byte %02h last %0b kind %0b",
                             seen.data, seen.fin, seen.kind);
            end
            else
            begin
                owed = owed_beats.pop_front();
                if (seen !== owed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("wrong beat: expected byte %02h last %0b kind %0b, %s",
                                 owed.data, owed.fin, owed.kind,
                                 $sformatf("got byte %02h last %0b kind %0b",
                                           seen.data, seen.fin, seen.kind));
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (rst_n)
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        settle();
        test_random_stream();
        settle();
        test_dictionary_growth();
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (owed_beats.size() != 0)
        begin
            $display("%0d expected beats never arrived", owed_beats.size());
            mismatches += owed_beats.size();
        end
        $display("Sent %0d input beats, decoded %0d codes, checked %0d result beats.",
                 beats_sent, codes_decoded, beats_checked);
        $display("Saw %0d refused bytes and %0d dictionary wraps; %0d checks failed.",
                 refusals, wraps, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/ld12_pkg.sv
src/ld12_ram.sv
src/ld12_unpack.sv
src/lzw_decoder_12bit_top.sv
src/ld12_checker.sv
bench/tb.sv
